/* src/mexp_pkg.sv */
// Package for the modular exponentiation block: widths, transaction types and sequencer states.
package mexp_pkg;

    // Operand width of base, modulus and result.
    localparam int OPERAND_BITS = 31;
    // Width of the private exponent register.
    localparam int EXP_BITS = 31;
    // Counter widths for the bit-serial step and the exponent bit index.
    localparam int STEP_W = $clog2(OPERAND_BITS);
    localparam int EBIT_W = $clog2(EXP_BITS);

    typedef logic [OPERAND_BITS-1:0] operand_t;
    typedef logic [EXP_BITS-1:0]     exponent_t;

    // Input transaction.
    typedef struct packed {
        operand_t base;
        operand_t modulus;
    } mexp_in_t;

    // Result transaction.
    typedef struct packed {
        operand_t result;
        logic     error;
    } mexp_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } mexp_state_t;

endpackage

/* src/modular_exponentiation.sv */
// Top level of the modular exponentiation block with its shared add-and-reduce unit.
//
//  Channel  | Ports                              | Carries
//  ---------+------------------------------------+-------------------------------
//  input    | s_valid, s_ready, s_data           | base and modulus
//  result   | m_valid, m_ready, m_data           | result and zero-modulus error
//  config   | cfg_wr_en, cfg_wr_data             | private exponent (reset 1)
//
// One transaction reduces the base, then for each of the EXP_BITS exponent bits squares and,
// when the bit is set, multiplies by the reduced base, and at last hands the result over.
// Every step runs on the single double-add-reduce unit, which retires one multiplier bit
// per cycle. A zero modulus goes straight to the hand-over. Reset is synchronous and active low.
// A finished result waits in the output register, so a stalled result channel only holds
// the sequencer once a second result is ready to be written.
module modular_exponentiation (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mexp_pkg::mexp_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mexp_pkg::mexp_out_t         m_data,
    input  logic                        cfg_wr_en,
    input  mexp_pkg::exponent_t         cfg_wr_data
);

    localparam int W = mexp_pkg::OPERAND_BITS;
    localparam logic [mexp_pkg::STEP_W-1:0] STEP_LAST = mexp_pkg::STEP_W'(W - 1);
    localparam logic [mexp_pkg::EBIT_W-1:0] EBIT_TOP  =
        mexp_pkg::EBIT_W'(mexp_pkg::EXP_BITS - 1);

    // Control registers.
    mexp_pkg::mexp_state_t           state_reg, state_next;
    logic                            m_valid_reg, m_valid_next;
    mexp_pkg::exponent_t             exp_reg, exp_next;
    logic [mexp_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [mexp_pkg::EBIT_W-1:0]     ebit_reg, ebit_next;

    // Datapath registers.
    mexp_pkg::operand_t              mod_reg, mod_next;
    mexp_pkg::operand_t              x_reg, x_next;
    mexp_pkg::operand_t              acc_reg, acc_next;
    mexp_pkg::operand_t              opa_reg, opa_next;
    mexp_pkg::operand_t              opb_reg, opb_next;
    logic                            err_reg, err_next;
    mexp_pkg::mexp_out_t             m_data_reg, m_data_next;

    // Shared unit signals.
    mexp_pkg::operand_t              addend;
    logic [W:0]                      dbl;
    mexp_pkg::operand_t              dbl_red;
    logic [W:0]                      sum;
    mexp_pkg::operand_t              unit_res;
    mexp_pkg::operand_t              one_mod;

    assign s_ready = (state_reg == mexp_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared unit: acc <- (2*acc + addend) mod m, with acc below m and addend no greater than m.
    // In reduction the addend is the next base bit; in multiplication it is the
    // multiplicand when the next multiplier bit is set.
    always_comb begin
        if (state_reg == mexp_pkg::ST_REDUCE) begin
            addend = W'(opb_reg[W-1]);
        end else begin
            addend = opb_reg[W-1] ? opa_reg : '0;
        end
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, mod_reg}) ? W'(dbl - {1'b0, mod_reg}) : dbl[W-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, addend};
        unit_res = (sum >= {1'b0, mod_reg}) ? W'(sum - {1'b0, mod_reg}) : sum[W-1:0];
    end

    // One reduced modulo the modulus: zero only when the modulus is one.
    assign one_mod = (mod_reg == W'(1)) ? '0 : W'(1);

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        exp_next     = exp_reg;
        step_next    = step_reg;
        ebit_next    = ebit_reg;
        mod_next     = mod_reg;
        x_next       = x_reg;
        acc_next     = acc_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        err_next     = err_reg;
        m_data_next  = m_data_reg;

        // The result register empties when its transaction is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            exp_next = cfg_wr_data;
        end

        case (state_reg)
            mexp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mod_next  = s_data.modulus;
                    opb_next  = s_data.base;
                    acc_next  = '0;
                    step_next = '0;
                    if (s_data.modulus == '0) begin
                        err_next   = 1'b1;
                        state_next = mexp_pkg::ST_FINISH;
                    end else begin
                        err_next   = 1'b0;
                        state_next = mexp_pkg::ST_REDUCE;
                    end
                end
            end

            // Base mod m, one base bit per cycle; then start squaring from 1 mod m.
            mexp_pkg::ST_REDUCE: begin
                acc_next  = unit_res;
                opb_next  = opb_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    x_next     = unit_res;
                    opa_next   = one_mod;
                    opb_next   = one_mod;
                    acc_next   = '0;
                    step_next  = '0;
                    ebit_next  = EBIT_TOP;
                    state_next = mexp_pkg::ST_SQUARE;
                end
            end

            // Squaring; when done, multiply by the base if the exponent bit is set.
            mexp_pkg::ST_SQUARE: begin
                acc_next  = unit_res;
                opb_next  = opb_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    step_next = '0;
                    if (exp_reg[ebit_reg]) begin
                        opa_next   = x_reg;
                        opb_next   = unit_res;
                        acc_next   = '0;
                        state_next = mexp_pkg::ST_MULT;
                    end else if (ebit_reg == '0) begin
                        state_next = mexp_pkg::ST_FINISH;
                    end else begin
                        opa_next   = unit_res;
                        opb_next   = unit_res;
                        acc_next   = '0;
                        ebit_next  = ebit_reg - 1'b1;
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end

            // Multiplication by the reduced base; then the next exponent bit.
            mexp_pkg::ST_MULT: begin
                acc_next  = unit_res;
                opb_next  = opb_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    step_next = '0;
                    if (ebit_reg == '0) begin
                        state_next = mexp_pkg::ST_FINISH;
                    end else begin
                        opa_next   = unit_res;
                        opb_next   = unit_res;
                        acc_next   = '0;
                        ebit_next  = ebit_reg - 1'b1;
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            mexp_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.result = acc_reg;
                    m_data_next.error  = err_reg;
                    m_valid_next       = 1'b1;
                    state_next         = mexp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mexp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            exp_reg     <= mexp_pkg::EXP_BITS'(1);
            step_reg    <= '0;
            ebit_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            exp_reg     <= exp_next;
            step_reg    <= step_next;
            ebit_reg    <= ebit_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mod_reg    <= mod_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* src/mexp_checker.sv */
// Port-level checker for the modular exponentiation block and its bind statement.
module mexp_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input mexp_pkg::mexp_out_t   m_data
);

    // A zero-modulus error always carries a zero result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.result == '0)
    else $error("error transaction with non-zero result");

    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
    else $error("input accepted again straight after a transaction");

    // After reset no result is offered and the input is open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
    else $error("block not empty after reset");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

/* test/modular_exponentiation_tb.sv */
// Self-checking testbench for the modular exponentiation block, with its own power predictor.
module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam mexp_pkg::operand_t  OPERAND_MAX  = '1;
    localparam mexp_pkg::exponent_t EXPONENT_MAX = '1;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    mexp_pkg::mexp_in_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    mexp_pkg::mexp_out_t m_data;
    logic                cfg_wr_en   = 1'b0;
    mexp_pkg::exponent_t cfg_wr_data = '0;

    // Operand pairs waiting to be driven and results still owed by the block.
    mexp_pkg::mexp_in_t  operands_q[$];
    mexp_pkg::mexp_out_t results_due_q[$];

    // Our copy of the exponent register, and the idling odds out of a hundred.
    mexp_pkg::exponent_t exponent_setting = mexp_pkg::exponent_t'(1);
    int                  send_idle_pct    = 0;
    int                  recv_stall_pct   = 0;
    int                  error_count      = 0;

    modular_exponentiation DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Expected result of raising the base to the exponent modulo the modulus.
    // Operands stay below two to the 31, so each product fits in 64 bits.
    function automatic mexp_pkg::mexp_out_t predict_power(mexp_pkg::mexp_in_t item,
                                                          mexp_pkg::exponent_t e);
        longint unsigned     m;
        longint unsigned     b;
        longint unsigned     acc;
        mexp_pkg::mexp_out_t r;
        int                  i;
        m       = item.modulus;
        b       = item.base;
        r.error = 1'b0;
        if (m == 0) begin
            r.result = '0;
            r.error  = 1'b1;
            return r;
        end
        b   = b % m;
        acc = 1 % m;
        for (i = mexp_pkg::EXP_BITS - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (e[i]) begin
                acc = (acc * b) % m;
            end
        end
        r.result = mexp_pkg::operand_t'(acc);
        return r;
    endfunction

    // One of the boundary values of an operand field.
    function automatic mexp_pkg::operand_t corner_operand();
        case ($urandom_range(3))
            0:       return '0;
            1:       return mexp_pkg::operand_t'(1);
            2:       return OPERAND_MAX - 1;
            default: return OPERAND_MAX;
        endcase
    endfunction

    // Random operands, weighted towards zero and unit moduli, small moduli and corners.
    function automatic mexp_pkg::mexp_in_t random_operands();
        mexp_pkg::mexp_in_t item;
        int                 pick;
        pick         = $urandom_range(99);
        item.base    = mexp_pkg::operand_t'($urandom);
        item.modulus = mexp_pkg::operand_t'($urandom);
        if (pick < 4) begin
            item.modulus = '0;
        end else if (pick < 8) begin
            item.modulus = mexp_pkg::operand_t'(1);
        end else if (pick < 18) begin
            item.modulus = mexp_pkg::operand_t'($urandom_range(2, 255));
        end else if (pick < 28) begin
            item.base    = corner_operand();
            item.modulus = corner_operand();
        end else if (pick < 36) begin
            item.modulus = mexp_pkg::operand_t'($urandom_range(1, 65535));
        end
        return item;
    endfunction

    task automatic add_operands(mexp_pkg::operand_t base, mexp_pkg::operand_t modulus);
        mexp_pkg::mexp_in_t item;
        item.base    = base;
        item.modulus = modulus;
        operands_q.push_back(item);
    endtask

    task automatic add_random(int count);
        repeat (count) operands_q.push_back(random_operands());
    endtask

    // Wait until every queued transaction has been sent and answered.
    task automatic drain();
        while (operands_q.size() != 0 || s_valid || results_due_q.size() != 0)
            @(posedge aclk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_exponent(mexp_pkg::exponent_t value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en        <= 1'b0;
        exponent_setting  = value;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Driver: records the prediction on acceptance, then offers the next pair or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                results_due_q.push_back(predict_power(s_data, exponent_setting));
            end
            if (!s_valid || s_ready) begin
                if (operands_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= operands_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        mexp_pkg::mexp_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due_q.size() == 0) begin
                    $display("%0t: result with none outstanding: result %0d error %0b",
                             $time, m_data.result, m_data.error);
                    error_count++;
                end else begin
                    want = results_due_q.pop_front();
                    if (m_data.result !== want.result) begin
                        $display("%0t: result mismatch: expected %0d, actual %0d",
                                 $time, want.result, m_data.result);
                        error_count++;
                    end
                    if (m_data.error !== want.error) begin
                        $display("%0t: error flag mismatch: expected %0b, actual %0b",
                                 $time, want.error, m_data.error);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks with the reset exponent of one: zero modulus, unit modulus,
        // base at or above the modulus and the field extremes.
        add_operands('0, '0);
        add_operands(OPERAND_MAX, '0);
        add_operands(OPERAND_MAX, OPERAND_MAX);
        add_operands(OPERAND_MAX, mexp_pkg::operand_t'(1));
        add_operands(mexp_pkg::operand_t'(5), mexp_pkg::operand_t'(7));
        add_operands(OPERAND_MAX, OPERAND_MAX - 1);
        add_operands(mexp_pkg::operand_t'(123456789), mexp_pkg::operand_t'(1000));
        add_operands('0, mexp_pkg::operand_t'(13));
        drain();

        // A zero exponent gives one modulo the modulus, including for a zero base.
        write_exponent('0);
        add_operands('0, OPERAND_MAX);
        add_operands(mexp_pkg::operand_t'(9), mexp_pkg::operand_t'(1));
        add_operands(mexp_pkg::operand_t'(2), mexp_pkg::operand_t'(3));
        add_operands(mexp_pkg::operand_t'(5), '0);
        drain();

        // Every exponent bit set, with large and small operands.
        write_exponent(EXPONENT_MAX);
        add_operands(OPERAND_MAX - 1, OPERAND_MAX);
        add_operands(mexp_pkg::operand_t'(2), OPERAND_MAX);
        add_operands(OPERAND_MAX, OPERAND_MAX - 2);
        add_operands(mexp_pkg::operand_t'(3), mexp_pkg::operand_t'(2));
        add_operands(mexp_pkg::operand_t'(31'h5555_5555), mexp_pkg::operand_t'(31'h2AAA_AAAA));
        add_operands(mexp_pkg::operand_t'(1), mexp_pkg::operand_t'(1000003));
        drain();

        // Random phases, each writing an exponent and setting an idling pattern.
        set_idling(0, 0);
        write_exponent(mexp_pkg::exponent_t'(65537));
        add_random(45);
        drain();

        set_idling(72, 0);
        write_exponent(mexp_pkg::exponent_t'($urandom));
        add_random(45);
        drain();

        set_idling(0, 72);
        write_exponent(EXPONENT_MAX);
        add_random(45);
        drain();

        set_idling(16, 16);
        write_exponent(mexp_pkg::exponent_t'($urandom));
        add_random(45);
        drain();

        set_idling(0, 72);
        write_exponent('0);
        add_random(45);
        drain();

        set_idling(16, 16);
        write_exponent(mexp_pkg::exponent_t'(2));
        add_random(47);
        drain();

        // Allow one full computation time for any stray result to show up.
        repeat (2000) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #25ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
